### rtl/pvs_pkg.sv
// ----------------------------------------------------------------------------
// pvs_pkg
// shared types, codes and tables of the polyphonic voice synthesizer
// ----------------------------------------------------------------------------
package pvs_pkg;

  localparam int NUM_VOICES_DEF     = 8;
  localparam int SAMPLES_PER_MS_DEF = 16;
  localparam int MS_MAX             = 4095;
  localparam int PEAK_W             = 15;
  localparam int S_W                = 18;
  localparam int QUOT_W             = 15;
  localparam int NB_W               = 5;
  localparam int HZ_TO_STEP         = 1049;
  localparam int CLAMP_MAX          = 32767;
  localparam int SQUARE_LEVEL       = 16000;
  localparam int WOBBLE_SHIFT       = 11;
  localparam logic [31:0] SEED_INIT = 32'h0123_4567;

  // quotient bit counts for the three divisions
  localparam logic [NB_W-1:0] NB_ATTACK = NB_W'(15);
  localparam logic [NB_W-1:0] NB_DECAY  = NB_W'(11);
  localparam logic [NB_W-1:0] NB_SWEEP  = NB_W'(8);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_NOISE = 2'd1,
    CMD_TONE  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_WOBBLE = 2'd2
  } wave_t;

  typedef enum logic [2:0] {
    KIND_OFF    = 3'd0,
    KIND_NOISE  = 3'd1,
    KIND_SINE   = 3'd2,
    KIND_SQUARE = 3'd3,
    KIND_WOBBLE = 3'd4
  } voice_kind_t;

  // request payload, first field in the highest bits
  typedef struct packed {
    logic        highpass_on;
    logic [7:0]  lowpass_coeff;
    logic [11:0] delay_ms;
    logic [11:0] attack_ms;
    logic [14:0] amplitude;
    logic [11:0] duration_ms;
    logic [12:0] end_hz;
    logic [12:0] start_hz;
    logic [1:0]  waveform;
  } in_fields_t;

  localparam int IN_DATA_W  = $bits(in_fields_t);
  localparam int OUT_DATA_W = 24;

  function automatic logic [31:0] xorshift(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  // parabolic sine
  localparam int SINE_FULL = 32767;
  localparam int SINE_DIV  = 127 * 127;

  typedef logic signed [15:0] sine_tab_t [256];

  function automatic sine_tab_t sine_table();
    sine_tab_t tab;
    int x;
    int y;
    for (int i = 0; i < 256; i++) begin
      x = (i & 127) * 2 - 127;
      y = SINE_FULL - (x * x * SINE_FULL) / SINE_DIV;
      tab[i] = (i < 128) ? 16'(y) : 16'(-y);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_ROM = sine_table();

endpackage

### rtl/polyphonic_voice_synth_core.sv
// ----------------------------------------------------------------------------
// polyphonic_voice_synth_core
// multi-voice sound effect synthesizer, one mixed sample per tick request
// ----------------------------------------------------------------------------
// the block holds one request at a time. a tick walks the voices in order,
// reading each busy voice's state from a one-port-read memory, running it and
// writing it back; an idle voice is skipped without a read. most of the work
// of a sounding voice lies in the shared one-bit-per-cycle divider (15
// quotient bits for the attack envelope or 11 for the decay envelope, plus 8
// for the tone sweep position). the result waits in an output register so
// the next request is taken at once; a tick ends only when that register is
// free or being read. a start request takes a free voice when there is one;
// else the voice with the least time left is found by scanning the memory.
// ----------------------------------------------------------------------------
module polyphonic_voice_synth_core #(
  parameter int NUM_VOICES     = pvs_pkg::NUM_VOICES_DEF,
  parameter int SAMPLES_PER_MS = pvs_pkg::SAMPLES_PER_MS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // effects_enable
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // waveform, start_hz, end_hz, duration_ms, amplitude, attack_ms,
  // delay_ms, lowpass_coeff, highpass_on
  input  logic [pvs_pkg::IN_DATA_W-1:0]    in_tdata,
  // cmd
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // sample, busy_voices
  output logic [pvs_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int VID_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int LEN_W    = $clog2(pvs_pkg::MS_MAX * SAMPLES_PER_MS + 1);
  localparam int TIME_W   = LEN_W + 1;
  localparam int DVD_W    = LEN_W + pvs_pkg::PEAK_W;
  localparam int MIX_W    = pvs_pkg::S_W + $clog2(NUM_VOICES + 1);
  localparam int BUSY_PAD = (NUM_VOICES > 8) ? NUM_VOICES : 8;
  localparam int S_W      = pvs_pkg::S_W;

  localparam logic signed [S_W-1:0]   SQ_HI  = S_W'(pvs_pkg::SQUARE_LEVEL);
  localparam logic signed [S_W-1:0]   SQ_LO  = -SQ_HI;
  localparam logic signed [MIX_W-1:0] MIX_HI = MIX_W'(pvs_pkg::CLAMP_MAX);
  localparam logic signed [MIX_W-1:0] MIX_LO = -MIX_HI;

  // per-voice state word
  typedef struct packed {
    logic signed [TIME_W-1:0] tm;
    logic [LEN_W-1:0]         length;
    logic [14:0]              peak;
    logic [LEN_W-1:0]         attack;
    logic [31:0]              phase;
    logic [23:0]              step_begin;
    logic [23:0]              step_finish;
    logic signed [16:0]       lp;
    logic [7:0]               lp_k;
    logic signed [16:0]       hp;
    logic                     hp_on;
    logic [31:0]              seed;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  typedef enum logic [4:0] {
    ST_IDLE, ST_PICK, ST_SCAN_RD, ST_SCAN_CMP, ST_WRITE,
    T_ISSUE, T_LOAD, T_CHECK, T_DLY, T_EDIV_GO, T_EDIV_WAIT, T_EMUL1, T_EMUL2,
    T_SRC, T_N1, T_N2, T_KDIV_GO, T_KDIV_WAIT, T_T1, T_T2, T_W1, T_W2, T_PH,
    T_OUT, T_ACC, T_NEXT, T_EMIT
  } state_t;

  state_t                   state_r;
  logic                     enable_r;
  logic [31:0]              seed_src_r;
  pvs_pkg::voice_kind_t     kind_r [NUM_VOICES];
  pvs_pkg::in_fields_t      inp_r;
  logic [1:0]               cmd_r;
  logic [VID_W-1:0]         v_r;
  logic [VID_W-1:0]         best_r;
  logic signed [TIME_W:0]   least_r;
  entry_t                   ent_r;
  logic signed [MIX_W-1:0]  mix_r;
  logic                     env_att_r;
  logic [DVD_W-1:0]         dvd_r;
  logic [LEN_W-1:0]         dsr_r;
  logic [pvs_pkg::NB_W-1:0] nb_r;
  logic [14:0]              e_r;
  logic [10:0]              f_r;
  logic [14:0]              pf_r;
  logic [7:0]               k_r;
  logic signed [17:0]       nd_r;
  logic signed [26:0]       np_r;
  logic signed [25:0]       sp_r;
  logic [31:0]              st_r;
  logic signed [40:0]       wp_r;
  logic signed [S_W-1:0]    s_r;
  logic signed [18:0]       vo_r;
  logic                     out_valid_r;
  logic [pvs_pkg::OUT_DATA_W-1:0] out_data_r;

  // memory port
  logic             rd_en;
  logic [ENT_W-1:0] rd_data;
  logic             wr_en;
  entry_t           wr_ent;
  entry_t           rd_ent;
  entry_t           new_ent;

  // divider port
  logic                       div_start;
  logic                       div_done;
  logic [pvs_pkg::QUOT_W-1:0] div_q;

  logic [NUM_VOICES-1:0] active;
  logic [BUSY_PAD-1:0]   act_pad;
  logic                  any_free;
  logic [VID_W-1:0]      free_idx;
  pvs_pkg::voice_kind_t  kind_new;
  logic [31:0]           seed_src_adv;
  logic [LEN_W-1:0]      delay_sc;

  // envelope and source helpers
  logic [LEN_W-1:0]          t_u;
  logic signed [LEN_W:0]     span;
  logic [LEN_W-1:0]          left_u;
  logic signed [TIME_W-1:0]  tm_inc;
  logic                      ends_now;
  logic signed [TIME_W:0]    left_scan;
  logic [31:0]               seed_adv;
  logic signed [15:0]        noise_n;
  logic signed [18:0]        lp_sum;
  logic signed [16:0]        lp_new;
  logic signed [17:0]        hp_diff;
  logic signed [17:0]        hp_sum;
  logic signed [24:0]        diff_st;
  logic signed [16:0]        ds;
  logic [LEN_W+2:0]          t7;
  logic signed [15:0]        wob_s;
  logic signed [40:0]        wsh;
  logic [31:0]               ph_new;
  logic signed [15:0]        s_sin;
  logic signed [S_W-1:0]     s_tone;
  logic signed [33:0]        vo_full;
  logic signed [15:0]        clamped;
  logic [25:0]               pf_full;
  logic [25:0]               e_full;

  pvs_ram #(
    .DEPTH  (NUM_VOICES),
    .DATA_W (ENT_W),
    .ADDR_W (VID_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (v_r),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (v_r),
    .rd_data (rd_data)
  );

  pvs_div #(
    .DVD_W (DVD_W),
    .DSR_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_r),
    .divisor  (dsr_r),
    .nbits    (nb_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign rd_ent = entry_t'(rd_data);

  // voice occupancy and first free voice
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      active[i] = (kind_r[i] != pvs_pkg::KIND_OFF);
      if (kind_r[i] == pvs_pkg::KIND_OFF) begin
        any_free = 1'b1;
        free_idx = VID_W'(i);
      end
    end
  end

  assign act_pad = BUSY_PAD'(active);

  // new voice set up from the latched start request
  always_comb begin
    if (cmd_r == pvs_pkg::CMD_NOISE) begin
      kind_new = pvs_pkg::KIND_NOISE;
    end else if (inp_r.waveform == pvs_pkg::WAVE_SQUARE) begin
      kind_new = pvs_pkg::KIND_SQUARE;
    end else if (inp_r.waveform == pvs_pkg::WAVE_WOBBLE) begin
      kind_new = pvs_pkg::KIND_WOBBLE;
    end else begin
      kind_new = pvs_pkg::KIND_SINE;
    end
  end

  assign seed_src_adv = pvs_pkg::xorshift(seed_src_r);
  assign delay_sc     = LEN_W'(32'(inp_r.delay_ms) * SAMPLES_PER_MS);

  always_comb begin
    new_ent.tm          = -$signed({1'b0, delay_sc});
    new_ent.length      = LEN_W'(32'(inp_r.duration_ms) * SAMPLES_PER_MS);
    new_ent.peak        = inp_r.amplitude;
    new_ent.attack      = LEN_W'(32'(inp_r.attack_ms) * SAMPLES_PER_MS);
    new_ent.phase       = '0;
    new_ent.step_begin  = 24'(32'(inp_r.start_hz) * pvs_pkg::HZ_TO_STEP);
    new_ent.step_finish = 24'(32'(inp_r.end_hz) * pvs_pkg::HZ_TO_STEP);
    new_ent.lp          = '0;
    new_ent.lp_k        = inp_r.lowpass_coeff;
    new_ent.hp          = '0;
    new_ent.hp_on       = inp_r.highpass_on;
    new_ent.seed        = seed_src_adv | 32'd1;
  end

  // time bookkeeping
  assign t_u       = ent_r.tm[LEN_W-1:0];
  assign span      = $signed({1'b0, ent_r.length}) - $signed({1'b0, ent_r.attack});
  assign left_u    = ent_r.length - t_u;
  assign tm_inc    = ent_r.tm + TIME_W'(1);
  assign ends_now  = (tm_inc >= $signed({1'b0, ent_r.length}));
  assign left_scan = (TIME_W+1)'($signed({1'b0, rd_ent.length})) - (TIME_W+1)'(rd_ent.tm);

  // envelope products
  assign pf_full = 26'(ent_r.peak) * 26'(f_r);
  assign e_full  = 26'(pf_r) * 26'(f_r);

  // noise source: xorshift into one-pole low-pass, optional high-pass
  assign seed_adv = pvs_pkg::xorshift(ent_r.seed);
  assign noise_n  = {~seed_adv[15], seed_adv[14:0]};
  assign lp_sum   = 19'(ent_r.lp) + 19'(np_r >>> 8);
  assign lp_new   = lp_sum[16:0];
  assign hp_diff  = 18'(lp_new) - 18'(ent_r.hp);
  assign hp_sum   = 18'(ent_r.hp) + (hp_diff >>> 4);

  // tone source: swept step, optional wobble, sine lookup
  assign diff_st = $signed({1'b0, ent_r.step_finish}) - $signed({1'b0, ent_r.step_begin});
  assign ds      = diff_st[24:8];
  assign t7      = {t_u, 3'b000} - {3'b000, t_u};
  assign wob_s   = pvs_pkg::SINE_ROM[t7[11:4]];
  assign wsh     = wp_r >>> pvs_pkg::WOBBLE_SHIFT;
  assign ph_new  = ent_r.phase + st_r;
  assign s_sin   = pvs_pkg::SINE_ROM[ph_new[23:16]];

  always_comb begin
    if (kind_r[v_r] == pvs_pkg::KIND_SQUARE) begin
      s_tone = ((s_sin > 0) ? SQ_HI : SQ_LO) + S_W'(s_sin >>> 2);
    end else begin
      s_tone = S_W'(s_sin);
    end
  end

  assign vo_full = s_r * $signed({1'b0, e_r});

  // clamp of the mix
  always_comb begin
    if (mix_r > MIX_HI) begin
      clamped = 16'(MIX_HI);
    end else if (mix_r < MIX_LO) begin
      clamped = 16'(MIX_LO);
    end else begin
      clamped = 16'(mix_r);
    end
  end

  // memory and divider control
  assign rd_en = ((state_r == T_ISSUE) && active[v_r]) || (state_r == ST_SCAN_RD);
  assign wr_en = (state_r == ST_WRITE) || (state_r == T_DLY) || (state_r == T_ACC);
  assign div_start = (state_r == T_EDIV_GO) || (state_r == T_KDIV_GO);

  always_comb begin
    wr_ent    = ent_r;
    wr_ent.tm = tm_inc;
    if (state_r == ST_WRITE) begin
      wr_ent = new_ent;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      seed_src_r  <= pvs_pkg::SEED_INIT;
      for (int i = 0; i < NUM_VOICES; i++) begin
        kind_r[i] <= pvs_pkg::KIND_OFF;
      end
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            inp_r <= pvs_pkg::in_fields_t'(in_tdata);
            cmd_r <= in_tuser;
            v_r   <= '0;
            mix_r <= '0;
            if (in_tuser == pvs_pkg::CMD_TICK) begin
              state_r <= T_ISSUE;
            end else if ((in_tuser == pvs_pkg::CMD_NOISE || in_tuser == pvs_pkg::CMD_TONE)
                         && enable_r) begin
              state_r <= ST_PICK;
            end
          end
        end
        ST_PICK: begin
          if (any_free) begin
            v_r     <= free_idx;
            state_r <= ST_WRITE;
          end else begin
            v_r     <= '0;
            state_r <= ST_SCAN_RD;
          end
        end
        ST_SCAN_RD: begin
          state_r <= ST_SCAN_CMP;
        end
        ST_SCAN_CMP: begin
          // least time left, lowest index on a tie
          if (v_r == '0 || left_scan < least_r) begin
            least_r <= left_scan;
            best_r  <= v_r;
          end
          if (v_r == VID_W'(NUM_VOICES - 1)) begin
            v_r     <= (v_r == '0 || left_scan < least_r) ? v_r : best_r;
            state_r <= ST_WRITE;
          end else begin
            v_r     <= v_r + 1'b1;
            state_r <= ST_SCAN_RD;
          end
        end
        ST_WRITE: begin
          kind_r[v_r] <= kind_new;
          if (cmd_r == pvs_pkg::CMD_NOISE) begin
            seed_src_r <= seed_src_adv;
          end
          state_r <= ST_IDLE;
        end
        T_ISSUE: begin
          state_r <= active[v_r] ? T_LOAD : T_NEXT;
        end
        T_LOAD: begin
          ent_r   <= rd_ent;
          state_r <= T_CHECK;
        end
        T_CHECK: begin
          if (ent_r.tm < 0) begin
            state_r <= T_DLY;
          end else if (t_u < ent_r.attack) begin
            dvd_r     <= DVD_W'(ent_r.peak) * DVD_W'(t_u);
            dsr_r     <= ent_r.attack;
            nb_r      <= pvs_pkg::NB_ATTACK;
            env_att_r <= 1'b1;
            state_r   <= T_EDIV_GO;
          end else if (span <= 0) begin
            e_r     <= '0;
            state_r <= T_SRC;
          end else begin
            dvd_r     <= DVD_W'({left_u, 10'b0});
            dsr_r     <= span[LEN_W-1:0];
            nb_r      <= pvs_pkg::NB_DECAY;
            env_att_r <= 1'b0;
            state_r   <= T_EDIV_GO;
          end
        end
        T_DLY: begin
          state_r <= T_NEXT;
        end
        T_EDIV_GO: begin
          state_r <= T_EDIV_WAIT;
        end
        T_EDIV_WAIT: begin
          if (div_done) begin
            if (env_att_r) begin
              e_r     <= div_q[14:0];
              state_r <= T_SRC;
            end else begin
              f_r     <= div_q[10:0];
              state_r <= T_EMUL1;
            end
          end
        end
        T_EMUL1: begin
          pf_r    <= pf_full[24:10];
          state_r <= T_EMUL2;
        end
        T_EMUL2: begin
          e_r     <= e_full[24:10];
          state_r <= T_SRC;
        end
        T_SRC: begin
          if (kind_r[v_r] == pvs_pkg::KIND_NOISE) begin
            ent_r.seed <= seed_adv;
            nd_r       <= 18'(noise_n) - 18'(ent_r.lp);
            state_r    <= T_N1;
          end else if (kind_r[v_r] == pvs_pkg::KIND_SINE ||
                       kind_r[v_r] == pvs_pkg::KIND_SQUARE ||
                       kind_r[v_r] == pvs_pkg::KIND_WOBBLE) begin
            if (ent_r.length == '0) begin
              k_r     <= '0;
              state_r <= T_T1;
            end else begin
              dvd_r   <= DVD_W'({t_u, 8'b0});
              dsr_r   <= ent_r.length;
              nb_r    <= pvs_pkg::NB_SWEEP;
              state_r <= T_KDIV_GO;
            end
          end else begin
            s_r     <= '0;
            state_r <= T_OUT;
          end
        end
        T_N1: begin
          np_r    <= nd_r * $signed({1'b0, ent_r.lp_k});
          state_r <= T_N2;
        end
        T_N2: begin
          ent_r.lp <= lp_new;
          if (ent_r.hp_on) begin
            s_r      <= hp_diff;
            ent_r.hp <= hp_sum[16:0];
          end else begin
            s_r <= S_W'(lp_new);
          end
          state_r <= T_OUT;
        end
        T_KDIV_GO: begin
          state_r <= T_KDIV_WAIT;
        end
        T_KDIV_WAIT: begin
          if (div_done) begin
            k_r     <= div_q[7:0];
            state_r <= T_T1;
          end
        end
        T_T1: begin
          sp_r    <= ds * $signed({1'b0, k_r});
          state_r <= T_T2;
        end
        T_T2: begin
          st_r    <= {8'b0, ent_r.step_begin} + 32'(sp_r);
          state_r <= (kind_r[v_r] == pvs_pkg::KIND_WOBBLE) ? T_W1 : T_PH;
        end
        T_W1: begin
          wp_r    <= $signed({1'b0, st_r[31:8]}) * wob_s;
          state_r <= T_W2;
        end
        T_W2: begin
          st_r    <= st_r + wsh[31:0];
          state_r <= T_PH;
        end
        T_PH: begin
          ent_r.phase <= ph_new;
          s_r         <= s_tone;
          state_r     <= T_OUT;
        end
        T_OUT: begin
          vo_r    <= vo_full[33:15];
          state_r <= T_ACC;
        end
        T_ACC: begin
          mix_r <= mix_r + MIX_W'(vo_r);
          if (ends_now) begin
            kind_r[v_r] <= pvs_pkg::KIND_OFF;
          end
          state_r <= T_NEXT;
        end
        T_NEXT: begin
          if (v_r == VID_W'(NUM_VOICES - 1)) begin
            state_r <= T_EMIT;
          end else begin
            v_r     <= v_r + 1'b1;
            state_r <= T_ISSUE;
          end
        end
        T_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {act_pad[7:0], clamped};
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // effects enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (cfg_wr_en) begin
      enable_r <= cfg_wr_data;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // divider finishes only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == T_EDIV_WAIT || state_r == T_KDIV_WAIT))
    else $error("divider result with no division pending");

  // a start request while disabled claims no voice
  a_disabled_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !enable_r &&
     (in_tuser == pvs_pkg::CMD_NOISE || in_tuser == pvs_pkg::CMD_TONE))
    |=> $stable(active))
    else $error("voice claimed while effects disabled");

  // the mix never leaves the symmetric clamp range
  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] != 16'h8000))
    else $error("sample outside clamp range");

  // a result appears only at the end of a tick
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == T_EMIT))
    else $error("result raised outside tick completion");
`endif

endmodule

### rtl/pvs_ram.sv
// ----------------------------------------------------------------------------
// pvs_ram
// voice state memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module pvs_ram #(
  parameter int DEPTH  = 8,
  parameter int DATA_W = 32,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/pvs_div.sv
// ----------------------------------------------------------------------------
// pvs_div
// serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pvs_div #(
  parameter int DVD_W = 31,
  parameter int DSR_W = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DVD_W-1:0]           dividend,
  input  logic [DSR_W-1:0]           divisor,
  input  logic [pvs_pkg::NB_W-1:0]   nbits,
  output logic                       done,
  output logic [pvs_pkg::QUOT_W-1:0] quotient
);

  localparam int SH_W = $clog2(DVD_W + 1);

  logic                     busy_r;
  logic                     done_r;
  logic [pvs_pkg::NB_W-1:0] cnt_r;
  logic [pvs_pkg::NB_W-1:0] nb_r;
  logic [DSR_W-1:0]         rem_r;
  logic [DSR_W-1:0]         dsr_r;
  logic [DVD_W-1:0]         work_r;

  logic [SH_W-1:0]  lsh;
  logic [DSR_W:0]   cand;
  logic [DSR_W+1:0] diff;
  logic             ge;

  assign lsh  = SH_W'(DVD_W) - SH_W'(nbits);
  assign cand = {rem_r, work_r[DVD_W-1]};
  assign diff = {1'b0, cand} - {2'b00, dsr_r};
  assign ge   = ~diff[DSR_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        nb_r   <= nbits;
        dsr_r  <= divisor;
        rem_r  <= DSR_W'(dividend >> nbits);
        work_r <= dividend << lsh;
      end else if (busy_r) begin
        rem_r  <= ge ? diff[DSR_W-1:0] : cand[DSR_W-1:0];
        work_r <= {work_r[DVD_W-2:0], ge};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == nb_r - 1'b1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = work_r[pvs_pkg::QUOT_W-1:0];

endmodule
